@@ rtl/length_prefixed_adler_frame_checker_macros.svh @@
// assertion macros for the length-prefixed adler frame checker
// no dependencies; define ASSERT_OFF to drop the checks
`ifndef LENGTH_PREFIXED_ADLER_FRAME_CHECKER_MACROS_SVH
`define LENGTH_PREFIXED_ADLER_FRAME_CHECKER_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define LPAF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LPAF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define LPAF_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define LPAF_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

@@ rtl/lpaf_pkg.sv @@
// shared types, widths and codes for the length-prefixed adler frame checker
// no dependencies
package lpaf_pkg;

  localparam int HEADER_BYTES = 4;
  localparam int LEN_W        = 27;
  localparam int CFG_INDEX_W  = 1;
  localparam int PH_W         = 2;

  localparam logic [LEN_W-1:0] MIN_LEN_RESET = LEN_W'(10);
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(67108864);
  localparam logic [31:0]      BODY_OVERHEAD = 32'(2 * HEADER_BYTES);

  localparam logic [16:0] ADLER_MOD = 17'd65521;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_LEN = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_LEN = 1'd1;

  // parser phases
  localparam logic [PH_W-1:0] PH_LEN     = 2'd0;
  localparam logic [PH_W-1:0] PH_NAMELEN = 2'd1;
  localparam logic [PH_W-1:0] PH_BODY    = 2'd2;
  localparam logic [PH_W-1:0] PH_CHECK   = 2'd3;

  // result item kinds
  localparam logic [1:0] KIND_NAME    = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_VERDICT = 2'd2;

  // verdict codes
  localparam logic [1:0] V_OK       = 2'd0;
  localparam logic [1:0] V_BAD_LEN  = 2'd1;
  localparam logic [1:0] V_BAD_SUM  = 2'd2;
  localparam logic [1:0] V_BAD_NAME = 2'd3;

  typedef struct packed {
    logic [1:0]       item_kind;
    logic [7:0]       byte_value;
    logic [1:0]       verdict;
    logic [LEN_W-1:0] frame_length;
    logic [LEN_W-1:0] type_name_length;
    logic             frame_end;
  } result_t;

endpackage

@@ rtl/length_prefixed_adler_frame_checker.sv @@
// length-prefixed frame checker with adler-32 body check
// an accepted byte's result, if any, is registered in the output register
// one byte per cycle while in_ready; adler update, length compares combinational
// reset: synchronous, active high; limits return to 10 and 67108864, parser
// waits for a length prefix, halt clears
// depends on lpaf_pkg, lpaf_adler, lpaf_out_stage and the macros header
`include "length_prefixed_adler_frame_checker_macros.svh"

module length_prefixed_adler_frame_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [lpaf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lpaf_pkg::LEN_W-1:0]       cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       rx_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       item_kind,
  output logic [7:0]                       byte_value,
  output logic [1:0]                       verdict,
  output logic [lpaf_pkg::LEN_W-1:0]       frame_length,
  output logic [lpaf_pkg::LEN_W-1:0]       type_name_length,
  output logic                             frame_end
);
  import lpaf_pkg::*;

  logic [LEN_W-1:0] min_frame_len;
  logic [LEN_W-1:0] max_frame_len;

  logic [PH_W-1:0]  phase;
  logic [LEN_W-1:0] byte_count;
  logic [31:0]      length_shift;
  logic [31:0]      name_length_reg;
  logic [31:0]      received_check;
  logic             halted;

  logic [PH_W-1:0]  phase_next;
  logic [LEN_W-1:0] byte_count_next;
  logic [31:0]      length_shift_next;
  logic [31:0]      name_length_reg_next;
  logic [31:0]      received_check_next;
  logic             halted_next;

  logic        accept;
  logic        work;
  logic        adler_en;
  logic        adler_clear;
  logic [31:0] adler_sum;
  logic        res_load;
  result_t     res;
  result_t     out_data;

  logic [LEN_W:0] count_inc;
  logic [31:0]    len_full;
  logic [31:0]    lo_min;
  logic [31:0]    body_limit;
  logic [31:0]    name_eff;
  logic [31:0]    check_full;

  assign accept = in_valid && in_ready;
  assign work   = accept && !halted;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_frame_len <= MIN_LEN_RESET;
      max_frame_len <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_LEN: min_frame_len <= cfg_data;
        REG_MAX_LEN: max_frame_len <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    count_inc  = {1'b0, byte_count} + 1'b1;
    len_full   = {length_shift[23:0], rx_byte};
    check_full = {received_check[23:0], rx_byte};
    lo_min     = ({5'd0, min_frame_len} > BODY_OVERHEAD) ? {5'd0, min_frame_len}
                                                         : BODY_OVERHEAD;
    body_limit = length_shift - BODY_OVERHEAD;
    // a negative name length means no name bytes at all
    name_eff   = name_length_reg[31] ? 32'd0 : name_length_reg;

    phase_next           = phase;
    byte_count_next      = byte_count;
    length_shift_next    = length_shift;
    name_length_reg_next = name_length_reg;
    received_check_next  = received_check;
    halted_next          = halted;
    adler_en             = 1'b0;
    adler_clear          = 1'b0;
    res_load             = 1'b0;
    res                  = '0;

    if (work) begin
      case (phase)
        PH_NAMELEN: begin
          adler_en             = 1'b1;
          name_length_reg_next = {name_length_reg[23:0], rx_byte};
          byte_count_next      = count_inc[LEN_W-1:0];
          if (count_inc >= (LEN_W+1)'(HEADER_BYTES)) begin
            byte_count_next = '0;
            phase_next      = (length_shift == BODY_OVERHEAD) ? PH_CHECK : PH_BODY;
          end
        end
        PH_BODY: begin
          adler_en        = 1'b1;
          byte_count_next = count_inc[LEN_W-1:0];
          if ({4'd0, count_inc} >= body_limit) begin
            byte_count_next = '0;
            phase_next      = PH_CHECK;
          end
          res_load       = 1'b1;
          res.item_kind  = ({5'd0, byte_count} < name_eff) ? KIND_NAME : KIND_PAYLOAD;
          res.byte_value = rx_byte;
        end
        PH_CHECK: begin
          received_check_next = check_full;
          byte_count_next     = count_inc[LEN_W-1:0];
          if (count_inc >= (LEN_W+1)'(HEADER_BYTES)) begin
            res_load             = 1'b1;
            res.item_kind        = KIND_VERDICT;
            res.frame_length     = length_shift[LEN_W-1:0];
            res.type_name_length = name_length_reg[LEN_W-1:0];
            res.frame_end        = 1'b1;
            // checksum mismatch wins over a bad name length
            if (check_full != adler_sum) begin
              res.verdict = V_BAD_SUM;
            end else if (name_length_reg[31] || name_length_reg < 32'd2 ||
                         name_length_reg > body_limit) begin
              res.verdict = V_BAD_NAME;
            end else begin
              res.verdict = V_OK;
            end
            halted_next          = (res.verdict != V_OK);
            phase_next           = PH_LEN;
            byte_count_next      = '0;
            length_shift_next    = '0;
            name_length_reg_next = '0;
            received_check_next  = '0;
            adler_clear          = 1'b1;
          end
        end
        default: begin
          length_shift_next = len_full;
          byte_count_next   = count_inc[LEN_W-1:0];
          if (count_inc >= (LEN_W+1)'(HEADER_BYTES)) begin
            byte_count_next = '0;
            if (len_full[31] || len_full > {5'd0, max_frame_len} || len_full < lo_min) begin
              res_load             = 1'b1;
              res.item_kind        = KIND_VERDICT;
              res.verdict          = V_BAD_LEN;
              res.frame_length     = len_full[LEN_W-1:0];
              res.type_name_length = name_length_reg[LEN_W-1:0];
              res.frame_end        = 1'b1;
              halted_next          = 1'b1;
            end else begin
              phase_next = PH_NAMELEN;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_LEN;
      byte_count      <= '0;
      length_shift    <= '0;
      name_length_reg <= '0;
      received_check  <= '0;
      halted          <= 1'b0;
    end else begin
      phase           <= phase_next;
      byte_count      <= byte_count_next;
      length_shift    <= length_shift_next;
      name_length_reg <= name_length_reg_next;
      received_check  <= received_check_next;
      halted          <= halted_next;
    end
  end

  lpaf_adler u_adler (
    .clk   (clk),
    .rst   (rst),
    .en    (adler_en),
    .clear (adler_clear),
    .data  (rx_byte),
    .sum   (adler_sum)
  );

  lpaf_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_load),
    .load_data (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .take      (in_ready)
  );

  assign item_kind        = out_data.item_kind;
  assign byte_value       = out_data.byte_value;
  assign verdict          = out_data.verdict;
  assign frame_length     = out_data.frame_length;
  assign type_name_length = out_data.type_name_length;
  assign frame_end        = out_data.frame_end;

  `LPAF_ASSERT_NEXT(a_halt_sticks, clk, rst, halted, halted, "halt released without reset")
  `LPAF_ASSERT_SAME(a_error_halts, clk, rst, out_valid && item_kind == KIND_VERDICT && verdict != V_OK, halted, "error verdict without halt")
  `LPAF_ASSERT_SAME(a_verdict_shape, clk, rst, out_valid && item_kind == KIND_VERDICT, frame_end && byte_value == 8'd0, "verdict item malformed")
  `LPAF_ASSERT_SAME(a_byte_shape, clk, rst, out_valid && item_kind != KIND_VERDICT, !frame_end && verdict == V_OK && frame_length == '0, "byte item malformed")

endmodule

@@ rtl/lpaf_adler.sv @@
// running adler-32 sums over the frame body, one byte per enable
// depends on lpaf_pkg
module lpaf_adler (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        clear,
  input  logic [7:0]  data,
  output logic [31:0] sum
);
  import lpaf_pkg::*;

  logic [15:0] low_sum;
  logic [15:0] high_sum;
  logic [15:0] low_sum_next;
  logic [15:0] high_sum_next;
  logic [16:0] low_add;
  logic [16:0] high_add;

  always_comb begin
    low_add = {1'b0, low_sum} + {9'd0, data};
    if (low_add >= ADLER_MOD) begin
      low_add = low_add - ADLER_MOD;
    end
    low_sum_next = low_add[15:0];
    high_add = {1'b0, high_sum} + {1'b0, low_sum_next};
    if (high_add >= ADLER_MOD) begin
      high_add = high_add - ADLER_MOD;
    end
    high_sum_next = high_add[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      low_sum  <= 16'd1;
      high_sum <= 16'd0;
    end else if (en) begin
      low_sum  <= low_sum_next;
      high_sum <= high_sum_next;
    end
  end

  assign sum = {high_sum, low_sum};

endmodule

@@ rtl/lpaf_out_stage.sv @@
// result register between the parser and the output channel
// depends on lpaf_pkg
module lpaf_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  lpaf_pkg::result_t load_data,
  input  logic             out_ready,
  output logic             out_valid,
  output lpaf_pkg::result_t out_data,
  output logic             take
);
  import lpaf_pkg::*;

  // a new request may enter when the slot is empty or is draining now
  assign take = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= load_data;
    end
  end

endmodule

@@ tb/sv/lpaf_result_checker.sv @@
// result checker for the length-prefixed adler frame checker: tracks the
// parser on every accepted byte and register write, compares each result
// depends on lpaf_pkg
module lpaf_result_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [lpaf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lpaf_pkg::LEN_W-1:0]       cfg_data,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic [7:0]                       rx_byte,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [1:0]                       item_kind,
  input  logic [7:0]                       byte_value,
  input  logic [1:0]                       verdict,
  input  logic [lpaf_pkg::LEN_W-1:0]       frame_length,
  input  logic [lpaf_pkg::LEN_W-1:0]       type_name_length,
  input  logic                             frame_end,
  output int                               mismatch_count,
  output int                               outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import lpaf_pkg::*;

  localparam logic [31:0] MIN_NAME_LEN = 32'd2;

  result_t          due_q[$];
  logic [LEN_W-1:0] min_len;
  logic [LEN_W-1:0] max_len;
  logic [PH_W-1:0]  phase;
  logic [31:0]      count;
  logic [31:0]      len_acc;
  logic [31:0]      name_acc;
  logic [31:0]      check_acc;
  logic [16:0]      sum_lo;
  logic [16:0]      sum_hi;
  logic             halted;

  task automatic start_frame();
    phase     = PH_LEN;
    count     = '0;
    len_acc   = '0;
    name_acc  = '0;
    check_acc = '0;
    sum_lo    = 17'd1;
    sum_hi    = '0;
  endtask

  task automatic fold_adler(input logic [7:0] b);
    sum_lo = sum_lo + b;
    if (sum_lo >= ADLER_MOD) sum_lo = sum_lo - ADLER_MOD;
    sum_hi = sum_hi + sum_lo;
    if (sum_hi >= ADLER_MOD) sum_hi = sum_hi - ADLER_MOD;
  endtask

  task automatic advance_parser(input logic [7:0] b);
    result_t     r;
    logic [31:0] name_eff;
    logic [31:0] lo_min;
    logic [31:0] body_len;
    r = '0;
    if (!halted) begin
      case (phase)
        PH_NAMELEN: begin
          fold_adler(b);
          name_acc = {name_acc[23:0], b};
          count++;
          if (count >= HEADER_BYTES) begin
            count = '0;
            phase = (len_acc == BODY_OVERHEAD) ? PH_CHECK : PH_BODY;
          end
        end
        PH_BODY: begin
          fold_adler(b);
          // a negative name length means the whole body is payload
          name_eff = name_acc[31] ? 32'd0 : name_acc;
          r.item_kind  = (count < name_eff) ? KIND_NAME : KIND_PAYLOAD;
          r.byte_value = b;
          due_q.push_back(r);
          count++;
          if (count >= len_acc - BODY_OVERHEAD) begin
            count = '0;
            phase = PH_CHECK;
          end
        end
        PH_CHECK: begin
          check_acc = {check_acc[23:0], b};
          count++;
          if (count >= HEADER_BYTES) begin
            body_len = len_acc - BODY_OVERHEAD;
            // checksum error wins over a bad name length
            if (check_acc != {sum_hi[15:0], sum_lo[15:0]}) begin
              r.verdict = V_BAD_SUM;
            end else if (name_acc[31] || name_acc < MIN_NAME_LEN || name_acc > body_len) begin
              r.verdict = V_BAD_NAME;
            end else begin
              r.verdict = V_OK;
            end
            r.item_kind        = KIND_VERDICT;
            r.frame_length     = len_acc[LEN_W-1:0];
            r.type_name_length = name_acc[LEN_W-1:0];
            r.frame_end        = 1'b1;
            due_q.push_back(r);
            if (r.verdict != V_OK) halted = 1'b1;
            start_frame();
          end
        end
        default: begin
          len_acc = {len_acc[23:0], b};
          count++;
          if (count >= HEADER_BYTES) begin
            count  = '0;
            lo_min = (32'(min_len) > BODY_OVERHEAD) ? 32'(min_len) : BODY_OVERHEAD;
            if (len_acc[31] || len_acc > 32'(max_len) || len_acc < lo_min) begin
              r.item_kind    = KIND_VERDICT;
              r.verdict      = V_BAD_LEN;
              r.frame_length = len_acc[LEN_W-1:0];
              r.frame_end    = 1'b1;
              due_q.push_back(r);
              halted = 1'b1;
            end else begin
              phase = PH_NAMELEN;
            end
          end
        end
      endcase
    end
  endtask

  task automatic check_field(input string tag, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, tag, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t head;
    if (rst) begin
      min_len        = MIN_LEN_RESET;
      max_len        = MAX_LEN_RESET;
      halted         = 1'b0;
      mismatch_count = 0;
      due_q.delete();
      start_frame();
    end else begin
      // results leave before this edge's byte can add a new one
      if (out_valid && out_ready) begin
        if (due_q.size() == 0) begin
          $display("%0t: unexpected result, expected none actual kind %0d byte %0d verdict %0d",
                   $time, item_kind, byte_value, verdict);
          mismatch_count++;
        end else begin
          head = due_q.pop_front();
          check_field("item_kind", 32'(head.item_kind), 32'(item_kind));
          check_field("byte_value", 32'(head.byte_value), 32'(byte_value));
          check_field("verdict", 32'(head.verdict), 32'(verdict));
          check_field("frame_length", 32'(head.frame_length), 32'(frame_length));
          check_field("type_name_length", 32'(head.type_name_length),
                      32'(type_name_length));
          check_field("frame_end", 32'(head.frame_end), 32'(frame_end));
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_MIN_LEN) min_len = cfg_data;
        else if (cfg_index == REG_MAX_LEN) max_len = cfg_data;
      end
      if (in_valid && in_ready) advance_parser(rx_byte);
    end
    outstanding = due_q.size();
  end

endmodule

@@ tb/sv/length_prefixed_adler_frame_checker_tb.sv @@
// top of the frame checker testbench: clock, reset, register writes, frame
// stimulus with random request gaps and output stalls, final verdict
// depends on lpaf_pkg, lpaf_result_checker and the block itself
module length_prefixed_adler_frame_checker_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lpaf_pkg::*;

  localparam int          CYCLE_LIMIT  = 1_000_000;
  localparam logic [31:0] MIN_GOOD_LEN = 32'd10;

  typedef logic [7:0] octet_q_t[$];
  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;
  typedef enum int {
    F_ABOVE_MAX, F_SIGN, F_BELOW_MIN, F_MIN_OVER_MAX, F_BAD_SUM, F_BAD_NAME
  } fault_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [LEN_W-1:0]       cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [7:0]             rx_byte;
  logic                   out_valid;
  logic                   out_ready;
  logic [1:0]             item_kind;
  logic [7:0]             byte_value;
  logic [1:0]             verdict;
  logic [LEN_W-1:0]       frame_length;
  logic [LEN_W-1:0]       type_name_length;
  logic                   frame_end;
  int                     mismatch_count;
  int                     outstanding;

  // what the stimulus believes the limits are
  logic [LEN_W-1:0] lim_min;
  logic [LEN_W-1:0] lim_max;
  int unsigned      bytes_sent;
  bit               steady_send;

  always #6 clk = ~clk;

  length_prefixed_adler_frame_checker u_dut (.*);

  lpaf_result_checker u_result_checker (.*);

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] adler_of(input octet_q_t data);
    logic [16:0] lo;
    logic [16:0] hi;
    lo = 17'd1;
    hi = '0;
    foreach (data[i]) begin
      lo = lo + data[i];
      if (lo >= ADLER_MOD) lo = lo - ADLER_MOD;
      hi = hi + lo;
      if (hi >= ADLER_MOD) hi = hi - ADLER_MOD;
    end
    return {hi[15:0], lo[15:0]};
  endfunction

  function automatic logic [31:0] pick_len();
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] cap;
    lo  = (32'(lim_min) > MIN_GOOD_LEN) ? 32'(lim_min) : MIN_GOOD_LEN;
    cap = ($urandom_range(0, 12) == 0) ? 32'd400 : 32'd48;
    hi  = (32'(lim_max) < cap) ? 32'(lim_max) : cap;
    return $urandom_range(lo, hi);
  endfunction

  function automatic logic [31:0] good_name_len(input logic [31:0] flen);
    case ($urandom_range(0, 4))
      0: return 32'd2;
      1: return flen - 8;
      default: return $urandom_range(2, flen - 8);
    endcase
  endfunction

  function automatic logic [31:0] bad_name_len(input logic [31:0] flen);
    case ($urandom_range(0, 3))
      0: return $urandom | 32'h8000_0000;
      1: return $urandom_range(0, 1);
      2: return flen - 7;
      default: return $urandom_range(flen - 7, 32'h7FFF_FFFF);
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int n;
    n = steady_send ? 0 : gap_len();
    if (n > 0) begin
      in_valid = 1'b0;
      repeat (n) @(negedge clk);
    end
    in_valid = 1'b1;
    rx_byte  = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) send_byte(w[8*i +: 8]);
  endtask

  task automatic send_frame(input logic [31:0] flen, input logic [31:0] name_len,
                            input logic [31:0] sum_flip, input fill_t fill);
    octet_q_t body;
    body = {};
    for (int i = 3; i >= 0; i--) body.push_back(name_len[8*i +: 8]);
    for (int unsigned i = 0; i < flen - 8; i++) begin
      case (fill)
        FILL_ZERO: body.push_back(8'h00);
        FILL_ONES: body.push_back(8'hFF);
        default:   body.push_back(8'($urandom));
      endcase
    end
    // a quarter of the frames go without request gaps
    steady_send = ($urandom_range(0, 3) == 0);
    send_word(flen);
    foreach (body[i]) send_byte(body[i]);
    send_word(adler_of(body) ^ sum_flip);
  endtask

  task automatic random_frames(input int unsigned budget);
    int unsigned start;
    logic [31:0] flen;
    fill_t       fill;
    int          r;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      flen = pick_len();
      r    = $urandom_range(0, 19);
      fill = (r < 3) ? FILL_ONES : (r == 3) ? FILL_ZERO : FILL_RANDOM;
      send_frame(flen, good_name_len(flen), 32'd0, fill);
    end
  endtask

  // drop valid and wait out every pending result plus the output register
  task automatic settle();
    in_valid    = 1'b0;
    steady_send = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [LEN_W-1:0] val);
    settle();
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_MIN_LEN) lim_min = val;
    else lim_max = val;
  endtask

  // output stalls: ready stretches of random length, some of them long
  initial begin
    int n;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = 1'b1;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
      repeat (n) @(negedge clk);
      n = gap_len();
      if (n > 0) begin
        out_ready = 1'b0;
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    fault_t      fault;
    logic [31:0] flen;
    logic [31:0] flip;
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = REG_MIN_LEN;
    cfg_data    = '0;
    in_valid    = 1'b0;
    rx_byte     = '0;
    lim_min     = MIN_LEN_RESET;
    lim_max     = MAX_LEN_RESET;
    bytes_sent  = 0;
    steady_send = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // smallest frame, a one-byte payload, then an all-name body
    send_frame(10, 2, 32'd0, FILL_ZERO);
    send_frame(11, 2, 32'd0, FILL_ONES);
    send_frame(12, 4, 32'd0, FILL_RANDOM);
    random_frames(200);

    write_reg(REG_MAX_LEN, LEN_W'(10));
    write_reg(REG_MIN_LEN, LEN_W'(10));
    random_frames(150);

    write_reg(REG_MIN_LEN, LEN_W'($urandom_range(10, 30)));
    write_reg(REG_MAX_LEN, lim_min + LEN_W'($urandom_range(0, 50)));
    random_frames(300);

    write_reg(REG_MIN_LEN, LEN_W'(10));
    write_reg(REG_MAX_LEN, MAX_LEN_RESET);
    // long run of 0xff wraps the low sum past the modulus
    send_frame(300, 2, 32'd0, FILL_ONES);
    random_frames(350);

    // any error halts the block for good, so the run closes on one of them
    fault = fault_t'($urandom_range(0, 5));
    case (fault)
      F_ABOVE_MAX: begin
        write_reg(REG_MAX_LEN, LEN_W'($urandom_range(10, 60)));
        flen = ($urandom_range(0, 1) == 1) ? 32'(lim_max) + 1
                                           : $urandom_range(32'(lim_max) + 1, 32'h7FFF_FFFF);
        send_word(flen);
      end
      F_SIGN: begin
        send_word($urandom | 32'h8000_0000);
      end
      F_BELOW_MIN: begin
        write_reg(REG_MIN_LEN, ($urandom_range(0, 1) == 1) ? LEN_W'($urandom_range(11, 60))
                                                           : MAX_LEN_RESET);
        flen = ($urandom_range(0, 1) == 1) ? 32'(lim_min) - 1
                                           : $urandom_range(0, 32'(lim_min) - 1);
        send_word(flen);
      end
      F_MIN_OVER_MAX: begin
        write_reg(REG_MAX_LEN, LEN_W'($urandom_range(10, 40)));
        write_reg(REG_MIN_LEN, ($urandom_range(0, 1) == 1) ? MAX_LEN_RESET
                                                           : lim_max + LEN_W'($urandom_range(1, 100)));
        send_word($urandom_range(32'(lim_max), 32'(lim_min)));
      end
      F_BAD_SUM: begin
        flen = pick_len();
        flip = ($urandom_range(0, 1) == 1) ? (32'd1 << $urandom_range(0, 31)) : $urandom;
        if (flip == 0) flip = 32'd1;
        send_frame(flen, ($urandom_range(0, 1) == 1) ? good_name_len(flen) : bad_name_len(flen),
                   flip, FILL_RANDOM);
      end
      default: begin
        flen = pick_len();
        send_frame(flen, bad_name_len(flen), 32'd0, FILL_RANDOM);
      end
    endcase
    // everything after the error must be swallowed
    repeat ($urandom_range(10, 40)) send_byte(8'($urandom));

    settle();
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/lpaf_pkg.sv
rtl/lpaf_adler.sv
rtl/lpaf_out_stage.sv
rtl/length_prefixed_adler_frame_checker.sv
tb/sv/lpaf_result_checker.sv
tb/sv/length_prefixed_adler_frame_checker_tb.sv
